@@ design/frustum_aabb_cull_unit_assert.svh @@
// Assertion macros for the frustum box cull unit.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef FRUSTUM_AABB_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_AABB_CULL_UNIT_ASSERT_SVH

`define FACU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FACU_IMPLIES(lbl, ante, cons, msg) \
  `FACU_ASSERT(lbl, (ante) |-> (cons), msg)

`define FACU_NEXT(lbl, ante, cons, msg) \
  `FACU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ design/facu_pkg.sv @@
`default_nettype none

package facu_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int PLANE_IDX_W     = 3;
  localparam int COEF_W          = 32;
  localparam int EXT_W           = 31;
  localparam int CORNER_W        = 33;
  localparam int PROD_W          = 65;
  localparam int ACC_W           = 67;
  localparam int D_SHIFT         = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } plane_t;

endpackage

`default_nettype wire

@@ design/frustum_aabb_cull_unit.sv @@
`default_nettype none
// Channel   Direction  Signals
// in_       input      in_valid, in_ready, in_operation, in_plane_index, plane and box fields
// out_      output     out_valid, out_ready, out_visible
//
// A plane load is taken and gives no result.
// A box test holds in_ready low until its result is registered: one shared signed multiplier
// forms one coefficient-times-corner product a cycle, three per plane, against the
// corner that maximizes the plane sum; an adder then accumulates and checks the sign.
// The result sits in an output register until it is taken; a later test waits in ST_FIN.
// Reset clears the control state and marks all planes as zero.

`include "frustum_aabb_cull_unit_assert.svh"

module frustum_aabb_cull_unit #(
  parameter int PLANE_COUNT = facu_pkg::PLANE_COUNT_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_operation,
  input  wire logic        [facu_pkg::PLANE_IDX_W-1:0] in_plane_index,
  input  wire logic signed [facu_pkg::COEF_W-1:0]     in_plane_a,
  input  wire logic signed [facu_pkg::COEF_W-1:0]     in_plane_b,
  input  wire logic signed [facu_pkg::COEF_W-1:0]     in_plane_c,
  input  wire logic signed [facu_pkg::COEF_W-1:0]     in_plane_d,
  input  wire logic signed [facu_pkg::COEF_W-1:0]     in_box_x,
  input  wire logic signed [facu_pkg::COEF_W-1:0]     in_box_y,
  input  wire logic signed [facu_pkg::COEF_W-1:0]     in_box_z,
  input  wire logic        [facu_pkg::EXT_W-1:0]      in_extent_x,
  input  wire logic        [facu_pkg::EXT_W-1:0]      in_extent_y,
  input  wire logic        [facu_pkg::EXT_W-1:0]      in_extent_z,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        out_visible
);

  localparam int PIDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int CW     = facu_pkg::CORNER_W;
  localparam int PW     = facu_pkg::PROD_W;
  localparam int AW     = facu_pkg::ACC_W;
  localparam int DW     = facu_pkg::COEF_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t                  state_r;
  logic [PIDX_W-1:0]       plane_r;
  logic [1:0]              axis_r;
  logic signed [CW-1:0]    lo_r [3];
  logic signed [CW-1:0]    hi_r [3];
  logic signed [PW-1:0]    prod_r;
  logic signed [AW-1:0]    acc_r;
  logic                    add_en_r;
  logic                    add_last_r;
  logic                    cull_r;
  logic                    out_valid_r;
  logic                    visible_r;
  logic [PLANE_COUNT-1:0]  plane_vld_r;
  facu_pkg::plane_t        plane_mem [PLANE_COUNT];

  facu_pkg::plane_t        row;
  logic signed [DW-1:0]    coef;
  logic signed [CW-1:0]    corner;
  logic signed [PW-1:0]    prod_nxt;
  logic signed [AW-1:0]    sum;
  logic signed [AW-1:0]    d_term;
  logic                    in_acc;
  logic                    wr_ok;
  logic [PIDX_W-1:0]       wr_idx;

  assign in_ready    = rst_n && (state_r == ST_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;
  assign wr_ok       = ({1'b0, in_plane_index} < 4'(PLANE_COUNT));
  assign wr_idx      = in_plane_index[PIDX_W-1:0];

  always_comb begin
    row = plane_vld_r[plane_r] ? plane_mem[plane_r] : '0;
    unique case (axis_r)
      facu_pkg::AXIS_X: begin
        coef   = row.a;
        corner = row.a[DW-1] ? lo_r[0] : hi_r[0];
      end
      facu_pkg::AXIS_Y: begin
        coef   = row.b;
        corner = row.b[DW-1] ? lo_r[1] : hi_r[1];
      end
      facu_pkg::AXIS_Z: begin
        coef   = row.c;
        corner = row.c[DW-1] ? lo_r[2] : hi_r[2];
      end
      default: begin
        coef   = '0;
        corner = '0;
      end
    endcase
    prod_nxt = PW'(coef) * PW'(corner);
    sum      = acc_r + {{(AW-PW){prod_r[PW-1]}}, prod_r};
    d_term   = {{(AW-DW-facu_pkg::D_SHIFT){row.d[DW-1]}}, row.d, {facu_pkg::D_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == facu_pkg::OP_LOAD) && wr_ok) begin
      plane_mem[wr_idx] <= '{a: in_plane_a, b: in_plane_b, c: in_plane_c, d: in_plane_d};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      add_en_r    <= 1'b0;
      plane_vld_r <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (add_en_r) begin
        if (!add_last_r) begin
          acc_r <= sum;
        end
        if (add_last_r && sum[AW-1]) begin
          cull_r <= 1'b1;
        end
      end
      add_en_r <= (state_r == ST_RUN);
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_operation == facu_pkg::OP_LOAD) begin
              if (wr_ok) begin
                plane_vld_r[wr_idx] <= 1'b1;
              end
            end else begin
              lo_r[0] <= CW'(in_box_x);
              lo_r[1] <= CW'(in_box_y);
              lo_r[2] <= CW'(in_box_z);
              hi_r[0] <= CW'(in_box_x) + CW'({1'b0, in_extent_x});
              hi_r[1] <= CW'(in_box_y) + CW'({1'b0, in_extent_y});
              hi_r[2] <= CW'(in_box_z) + CW'({1'b0, in_extent_z});
              plane_r <= '0;
              axis_r  <= facu_pkg::AXIS_X;
              cull_r  <= 1'b0;
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          prod_r     <= prod_nxt;
          add_last_r <= (axis_r == facu_pkg::AXIS_Z);
          if (axis_r == facu_pkg::AXIS_X) begin
            acc_r <= d_term;
          end
          unique case (axis_r)
            facu_pkg::AXIS_X: axis_r <= facu_pkg::AXIS_Y;
            facu_pkg::AXIS_Y: axis_r <= facu_pkg::AXIS_Z;
            default: begin
              axis_r <= facu_pkg::AXIS_X;
              if (plane_r == PIDX_W'(PLANE_COUNT - 1)) begin
                state_r <= ST_DRAIN;
              end else begin
                plane_r <= plane_r + PIDX_W'(1);
              end
            end
          endcase
        end
        ST_DRAIN: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            visible_r   <= !cull_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `FACU_IMPLIES(a_rose_from_fin, $rose(out_valid_r), $past(state_r == ST_FIN), "result without test")
  `FACU_IMPLIES(a_add_in_test, add_en_r, (state_r == ST_RUN || state_r == ST_DRAIN), "stray add")
  `FACU_IMPLIES(a_plane_wrap, (add_last_r && add_en_r && state_r == ST_RUN), (axis_r == facu_pkg::AXIS_X), "axis misaligned")
  `FACU_NEXT(a_test_starts, (in_acc && in_operation == facu_pkg::OP_TEST), (state_r == ST_RUN && plane_r == '0), "test did not start")

endmodule

`default_nettype wire
